// ===== rtl/hbmc_pkg.sv =====
// hbmc_pkg: types, codes, widths and reset values for the h-bridge motor command unit
// no dependencies; imported by h_bridge_motor_command_unit
`timescale 1ns / 1ps

package hbmc_pkg;

  // defaults for the top level parameters
  localparam int MotorsDflt   = 4;
  localparam int DutyBitsDflt = 16;

  // field and register widths
  localparam int ReqW     = 3;
  localparam int IdxW     = 2;
  localparam int SpeedW   = 17;
  localparam int PeriodW  = 16;
  localparam int CmdMaxW  = 16;
  localparam int CountW   = 3;
  localparam int MaskW    = 4;
  localparam int DutyOutW = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int ProdW    = PeriodW + CmdMaxW;

  // request codes
  localparam logic [ReqW-1:0] ReqSetSpeed = 3'd0;
  localparam logic [ReqW-1:0] ReqStop     = 3'd1;
  localparam logic [ReqW-1:0] ReqPowerOn  = 3'd2;
  localparam logic [ReqW-1:0] ReqPowerOff = 3'd3;
  localparam logic [ReqW-1:0] ReqStopAll  = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPwmPeriod  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCommandMax = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMotorCount = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRevMask    = 2'd3;

  // direction codes
  localparam logic [1:0] DirStop = 2'b00;
  localparam logic [1:0] DirFwd  = 2'b01;
  localparam logic [1:0] DirRev  = 2'b11;

  // bridge pin pairs, pin_a in bit 1
  localparam logic [1:0] PinsCoast = 2'b00;
  localparam logic [1:0] PinsFwd   = 2'b10;
  localparam logic [1:0] PinsRev   = 2'b01;
  localparam logic [1:0] PinsBrake = 2'b11;

  // register reset values
  localparam logic [PeriodW-1:0] PwmPeriodRst  = 16'd1000;
  localparam logic [CmdMaxW-1:0] CommandMaxRst = 16'd1000;
  localparam logic [CountW-1:0]  MotorCountRst = 3'd2;
  localparam logic [MaskW-1:0]   RevMaskRst    = 4'd0;

  // serial multiply (two bits a step) and divide (one bit a step)
  localparam int StepW    = 4;
  localparam int MulSteps = CmdMaxW / 2;
  localparam int DivSteps = PeriodW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_UPDATE,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/h_bridge_motor_command_unit.sv =====
// h_bridge_motor_command_unit: motor command decode, serial duty divider and per-motor state
// depends on hbmc_pkg
`timescale 1ns / 1ps
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------------
//  in       | input     | in_valid/in_ready   | req_type, motor_index, speed_command,
//           |           |                     | stop_coast
//  out      | output    | out_valid/out_ready | motor_out, pin_a, pin_b, duty_out, status,
//           |           |                     | power_on_out, last_result
//  cfg      | input     | cfg_we (no wait)    | cfg_idx, cfg_wdata
//
//  a running set speed goes through decode, the radix-4 serial multiplier, a round-up add,
//  the bit-serial restoring divider, the motor update and emit
//  stop, brake, rejects and set speed that needs no duty go from decode straight to emit
//  power enable, power disable and stop all emit one result for each motor in use
//  one item in flight; a new item is taken while the last result still waits in the output
//  register, and a stalled output holds the emit sequence
//  async active-low reset: configuration registers to their defaults, all motors coast, power off

module h_bridge_motor_command_unit import hbmc_pkg::*; #(
  parameter int MOTORS    = MotorsDflt,
  parameter int DUTY_BITS = DutyBitsDflt
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration writes
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i,
  // command channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ReqW-1:0]            req_type_i,
  input  logic [IdxW-1:0]            motor_index_i,
  input  logic signed [SpeedW-1:0]   speed_command_i,
  input  logic                       stop_coast_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [IdxW-1:0]            motor_out_o,
  output logic                       pin_a_o,
  output logic                       pin_b_o,
  output logic [DutyOutW-1:0]        duty_out_o,
  output logic                       status_o,
  output logic                       power_on_out_o,
  output logic                       last_result_o
);

  // only four motors are addressable
  localparam int Slots = (MOTORS < 4) ? MOTORS : 4;

  state_e state_q, state_d;

  // configuration
  logic [PeriodW-1:0] period_q;
  logic [CmdMaxW-1:0] cmax_q;
  logic [CountW-1:0]  count_q;
  logic [MaskW-1:0]   mask_q;

  // latched request
  logic [ReqW-1:0]   req_q;
  logic [IdxW-1:0]   idx_q;
  logic [SpeedW-1:0] raw_q;
  logic              coast_q;

  // motor state
  logic                 power_q;
  logic [1:0]           pins_q [Slots];
  logic [1:0]           dir_q  [Slots];
  logic [DUTY_BITS-1:0] duty_q [Slots];

  // serial arithmetic
  logic [ProdW-1:0]   prod_q;
  logic [CmdMaxW-1:0] mplier_q;
  logic [StepW-1:0]   step_q;
  logic               neg_q;

  // emit sequence
  logic [IdxW-1:0] emit_idx_q;
  logic            bcast_q;
  logic            show_q;
  logic            status_q;

  // output register
  logic                out_valid_q;
  logic [IdxW-1:0]     motor_out_q;
  logic [1:0]          pins_out_q;
  logic [DutyOutW-1:0] duty_out_q;
  logic                status_out_q;
  logic                power_out_q;
  logic                last_out_q;

  // decode
  logic [CountW-1:0]  n_use;
  logic               idx_valid;
  logic [SpeedW-1:0]  abs_cmd;
  logic [CmdMaxW-1:0] mag;
  logic               mag_zero;
  logic               is_bcast;
  logic               is_bad;
  logic               go_mul;
  logic               pwr_reject;

  // fsm outputs
  logic             coast_all;
  logic [Slots-1:0] coast_we;
  logic [Slots-1:0] brake_we;
  logic [Slots-1:0] run_we;
  logic             power_we;
  logic             power_val;
  logic             emit_fire;
  logic             emit_last;

  // datapath helpers
  logic [1:0]           pp_digit;
  logic [PeriodW+1:0]   pp;
  logic [CmdMaxW:0]     div_t;
  logic                 div_ge;
  logic [CmdMaxW-1:0]   div_rem;
  logic [1:0]           dir_sel;
  logic [1:0]           pins_sel;
  logic [DUTY_BITS-1:0] duty_sel;
  logic [1:0]           new_dir;
  logic                 reversal;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PwmPeriodRst;
      cmax_q   <= CommandMaxRst;
      count_q  <= MotorCountRst;
      mask_q   <= RevMaskRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPwmPeriod:  period_q <= cfg_wdata_i[PeriodW-1:0];
        CfgCommandMax: cmax_q   <= cfg_wdata_i[CmdMaxW-1:0];
        CfgMotorCount: count_q  <= cfg_wdata_i[CountW-1:0];
        CfgRevMask:    mask_q   <= cfg_wdata_i[MaskW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- decode
  assign n_use     = (count_q > CountW'(Slots)) ? CountW'(Slots) : count_q;
  assign idx_valid = ({1'b0, idx_q} < n_use);
  assign abs_cmd   = raw_q[SpeedW-1] ? (~raw_q + SpeedW'(1)) : raw_q;
  assign mag       = (abs_cmd > {1'b0, cmax_q}) ? cmax_q : abs_cmd[CmdMaxW-1:0];
  assign mag_zero  = (mag == '0);
  assign is_bcast  = (req_q == ReqPowerOn) || (req_q == ReqPowerOff) || (req_q == ReqStopAll);
  assign is_bad    = (req_q > ReqStopAll) || !idx_valid;
  assign pwr_reject = (req_q == ReqSetSpeed) && !mag_zero && !power_q;
  assign go_mul    = (req_q == ReqSetSpeed) && !is_bad && !mag_zero && power_q;

  // ---------------------------------------------------------------- read selects
  always_comb begin
    dir_sel = DirStop;
    for (int i = 0; i < Slots; i++) begin
      if (idx_q == IdxW'(i)) begin
        dir_sel = dir_q[i];
      end
    end
  end

  always_comb begin
    pins_sel = PinsCoast;
    duty_sel = '0;
    for (int i = 0; i < Slots; i++) begin
      if (show_q && (emit_idx_q == IdxW'(i))) begin
        pins_sel = pins_q[i];
        duty_sel = duty_q[i];
      end
    end
  end

  assign new_dir  = neg_q ? DirRev : DirFwd;
  assign reversal = (dir_sel != DirStop) && (dir_sel != new_dir);

  assign emit_last = !bcast_q || ({1'b0, emit_idx_q} == (n_use - CountW'(1)));
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (is_bcast && (n_use == '0)) state_d = ST_IDLE;
        else if (go_mul)               state_d = ST_MUL;
        else                           state_d = ST_EMIT;
      end
      ST_MUL: begin
        if (step_q == StepW'(MulSteps - 1)) state_d = ST_ADD;
      end
      ST_ADD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (step_q == StepW'(DivSteps - 1)) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire && emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- fsm outputs
  always_comb begin
    in_ready_o = 1'b0;
    coast_all  = 1'b0;
    coast_we   = '0;
    brake_we   = '0;
    run_we     = '0;
    power_we   = 1'b0;
    power_val  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_DECODE: begin
        coast_all = (req_q == ReqPowerOn) || (req_q == ReqPowerOff);
        power_we  = coast_all;
        power_val = (req_q == ReqPowerOn);
        for (int i = 0; i < Slots; i++) begin
          if (CountW'(i) < n_use) begin
            if (coast_all) coast_we[i] = 1'b1;
            if (req_q == ReqStopAll) brake_we[i] = 1'b1;
          end
          if (!is_bad && (idx_q == IdxW'(i))) begin
            if (req_q == ReqStop) begin
              if (coast_q) coast_we[i] = 1'b1;
              else         brake_we[i] = 1'b1;
            end
            if ((req_q == ReqSetSpeed) && mag_zero) brake_we[i] = 1'b1;
          end
        end
      end
      ST_UPDATE: begin
        for (int i = 0; i < Slots; i++) begin
          if (idx_q == IdxW'(i)) begin
            if (reversal) coast_we[i] = 1'b1;
            else          run_we[i]   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // ---------------------------------------------------------------- request capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q   <= req_type_i;
      idx_q   <= motor_index_i;
      raw_q   <= $unsigned(speed_command_i);
      coast_q <= stop_coast_i;
    end
  end

  // ---------------------------------------------------------------- serial multiply and divide
  assign pp_digit = mplier_q[CmdMaxW-1 -: 2];
  assign pp       = (pp_digit[1] ? {1'b0, period_q, 1'b0} : '0)
                  + (pp_digit[0] ? {2'b00, period_q} : '0);
  assign div_t    = {prod_q[ProdW-1 -: CmdMaxW], prod_q[PeriodW-1]};
  assign div_ge   = (div_t >= {1'b0, cmax_q});
  assign div_rem  = div_ge ? CmdMaxW'(div_t - {1'b0, cmax_q}) : div_t[CmdMaxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      case (state_q)
        ST_MUL: begin
          if (step_q == StepW'(MulSteps - 1)) step_q <= '0;
          else                                step_q <= step_q + StepW'(1);
        end
        ST_DIV:  step_q <= step_q + StepW'(1);
        default: step_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_DECODE: begin
        prod_q   <= '0;
        mplier_q <= mag;
        neg_q    <= raw_q[SpeedW-1] ^ mask_q[idx_q];
      end
      ST_MUL: begin
        prod_q   <= {prod_q[ProdW-3:0], 2'b00} + ProdW'(pp);
        mplier_q <= {mplier_q[CmdMaxW-3:0], 2'b00};
      end
      // rounding up: add divisor minus one before dividing
      ST_ADD: prod_q <= prod_q + ProdW'(cmax_q) - ProdW'(1);
      ST_DIV: prod_q <= {div_rem, prod_q[PeriodW-2:0], div_ge};
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- motor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       power_q <= 1'b0;
    else if (power_we) power_q <= power_val;
  end

  for (genvar g = 0; g < Slots; g++) begin : g_motor
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pins_q[g] <= PinsCoast;
        dir_q[g]  <= DirStop;
        duty_q[g] <= DUTY_BITS'(PwmPeriodRst);
      end else if (coast_we[g]) begin
        pins_q[g] <= PinsCoast;
        dir_q[g]  <= DirStop;
        duty_q[g] <= DUTY_BITS'(period_q);
      end else if (brake_we[g]) begin
        pins_q[g] <= PinsBrake;
        dir_q[g]  <= DirStop;
        duty_q[g] <= '0;
      end else if (run_we[g]) begin
        if (dir_q[g] == DirStop) pins_q[g] <= neg_q ? PinsRev : PinsFwd;
        dir_q[g]  <= new_dir;
        duty_q[g] <= DUTY_BITS'(prod_q[PeriodW-1:0]);
      end
    end
  end

  // ---------------------------------------------------------------- emit sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_idx_q <= '0;
      bcast_q    <= 1'b0;
      show_q     <= 1'b0;
      status_q   <= 1'b0;
    end else if (state_q == ST_DECODE) begin
      emit_idx_q <= is_bcast ? '0 : idx_q;
      bcast_q    <= is_bcast;
      show_q     <= is_bcast || idx_valid;
      status_q   <= !is_bcast && (is_bad || pwr_reject);
    end else if (emit_fire) begin
      emit_idx_q <= emit_idx_q + IdxW'(1);
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                     out_valid_q <= 1'b0;
    else if (emit_fire)              out_valid_q <= 1'b1;
    else if (out_ready_i)            out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      motor_out_q  <= emit_idx_q;
      pins_out_q   <= pins_sel;
      duty_out_q   <= DutyOutW'(duty_sel);
      status_out_q <= status_q;
      power_out_q  <= power_q;
      last_out_q   <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign motor_out_o    = motor_out_q;
  assign pin_a_o        = pins_out_q[1];
  assign pin_b_o        = pins_out_q[0];
  assign duty_out_o     = duty_out_q;
  assign status_o       = status_out_q;
  assign power_on_out_o = power_out_q;
  assign last_result_o  = last_out_q;

`ifndef SYNTHESIS
  // dividend high half stays below the divisor so the quotient fits
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && step_q == '0) |-> (prod_q[ProdW-1 -: CmdMaxW] < cmax_q))
    else $error("divider start remainder not below divisor");

  // remainder after the last divide step is below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> (prod_q[ProdW-1 -: CmdMaxW] < cmax_q))
    else $error("divider remainder out of range");

  // a running update touches one motor and never with coast or brake on it
  a_run_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(run_we) && ((run_we & (coast_we | brake_we)) == '0))
    else $error("conflicting motor updates");

  // a stalled result keeps the emit sequence waiting
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_valid_q && !out_ready_i) |=>
      (state_q == ST_EMIT && $stable(emit_idx_q)))
    else $error("emit advanced while output stalled");

  // no new command is taken while the multiplier or divider is busy
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_DIV) |-> !in_ready_o)
    else $error("transfer accepted during duty computation");
`endif

endmodule

// ===== sim/tb_h_bridge_motor_command_unit.sv =====
`timescale 1ns / 1ps
// tb_h_bridge_motor_command_unit: self-checking bench for the h-bridge motor command unit
// directed and random command traffic checked against a behavioral model of pins and duty
// depends on hbmc_pkg and h_bridge_motor_command_unit

module tb_h_bridge_motor_command_unit;
  import hbmc_pkg::*;

  localparam int NumMotors   = MotorsDflt;
  localparam int DrainCycles = 40;
  localparam int StallLimit  = 2000;
  localparam int MaxReports  = 10;

  localparam logic [ReqW-1:0] ReqUnusedLo = 3'd5;
  localparam logic [ReqW-1:0] ReqUnusedHi = 3'd7;

  typedef struct packed {
    logic [IdxW-1:0]     motor;
    logic                pin_a;
    logic                pin_b;
    logic [DutyOutW-1:0] duty;
    logic                status;
    logic                power;
    logic                last;
  } motor_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CfgIdxW-1:0]       cfg_idx;
  logic [CfgDataW-1:0]      cfg_wdata;
  logic                     in_valid;
  logic                     in_ready_o;
  logic [ReqW-1:0]          req_type;
  logic [IdxW-1:0]          motor_index;
  logic signed [SpeedW-1:0] speed_command;
  logic                     stop_coast;
  logic                     out_valid_o;
  logic                     out_ready;
  logic [IdxW-1:0]          motor_out_o;
  logic                     pin_a_o;
  logic                     pin_b_o;
  logic [DutyOutW-1:0]      duty_out_o;
  logic                     status_o;
  logic                     power_on_out_o;
  logic                     last_result_o;

  // model state and register copies
  logic [1:0]         dir_state    [NumMotors];
  logic [1:0]         bridge_state [NumMotors];
  logic [PeriodW-1:0] duty_state   [NumMotors];
  logic               power_state;
  logic [PeriodW-1:0] period_cfg;
  logic [CmdMaxW-1:0] cmax_cfg;
  logic [CountW-1:0]  count_cfg;
  logic [MaskW-1:0]   revmask_cfg;

  motor_result_t expected_results_q[$];

  bit idle_en;
  bit stall_en;
  int stall_left;
  int mismatches;
  int commands_sent;
  int results_seen;
  int cfg_writes;
  int quiet_cycles;

  h_bridge_motor_command_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type),
    .motor_index_i  (motor_index),
    .speed_command_i(speed_command),
    .stop_coast_i   (stop_coast),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .motor_out_o    (motor_out_o),
    .pin_a_o        (pin_a_o),
    .pin_b_o        (pin_b_o),
    .duty_out_o     (duty_out_o),
    .status_o       (status_o),
    .power_on_out_o (power_on_out_o),
    .last_result_o  (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- model ----------------

  function automatic int unsigned motors_active();
    return (int'(count_cfg) > NumMotors) ? NumMotors : int'(count_cfg);
  endfunction

  function automatic void push_result(int m, bit show, bit rejected, bit last);
    motor_result_t r;
    r.motor  = m[IdxW-1:0];
    r.pin_a  = show ? bridge_state[m][1] : 1'b0;
    r.pin_b  = show ? bridge_state[m][0] : 1'b0;
    r.duty   = show ? duty_state[m] : '0;
    r.status = rejected;
    r.power  = power_state;
    r.last   = last;
    expected_results_q.push_back(r);
  endfunction

  function automatic void coast_motor(int m);
    bridge_state[m] = PinsCoast;
    duty_state[m]   = period_cfg;
    dir_state[m]    = DirStop;
  endfunction

  function automatic void brake_motor(int m);
    bridge_state[m] = PinsBrake;
    duty_state[m]   = '0;
    dir_state[m]    = DirStop;
  endfunction

  function automatic void predict_command(logic [ReqW-1:0] req, logic [IdxW-1:0] idx,
                                          logic signed [SpeedW-1:0] speed, logic coast);
    int unsigned n;
    bit in_use;
    longint cmd;
    longint lim;
    longint unsigned mag;
    longint unsigned duty;
    logic [1:0] dir;
    n = motors_active();
    in_use = (idx < n);
    if (req == ReqPowerOn || req == ReqPowerOff || req == ReqStopAll) begin
      for (int i = 0; i < n; i++) begin
        if (req == ReqStopAll) brake_motor(i);
        else coast_motor(i);
      end
      if (req == ReqPowerOn) power_state = 1'b1;
      else if (req == ReqPowerOff) power_state = 1'b0;
      for (int i = 0; i < n; i++) push_result(i, 1'b1, 1'b0, (i + 1) == n);
      return;
    end
    if (req > ReqStopAll || !in_use) begin
      push_result(idx, in_use, 1'b1, 1'b1);
      return;
    end
    if (req == ReqStop) begin
      if (coast) coast_motor(idx);
      else brake_motor(idx);
      push_result(idx, 1'b1, 1'b0, 1'b1);
      return;
    end
    cmd = longint'(speed);
    lim = longint'(cmax_cfg);
    if (cmd > lim) cmd = lim;
    else if (cmd < -lim) cmd = -lim;
    if (revmask_cfg[idx]) cmd = -cmd;
    if (cmd == 0) begin
      brake_motor(idx);
      push_result(idx, 1'b1, 1'b0, 1'b1);
      return;
    end
    if (!power_state) begin
      push_result(idx, 1'b1, 1'b1, 1'b1);
      return;
    end
    dir  = (cmd > 0) ? DirFwd : DirRev;
    mag  = (cmd > 0) ? cmd : -cmd;
    duty = (mag * period_cfg + cmax_cfg - 1) / cmax_cfg;
    if (dir_state[idx] != DirStop && dir_state[idx] != dir) begin
      coast_motor(idx);
    end else begin
      if (dir_state[idx] == DirStop) bridge_state[idx] = (dir == DirFwd) ? PinsFwd : PinsRev;
      duty_state[idx] = duty[PeriodW-1:0];
      dir_state[idx]  = dir;
    end
    push_result(idx, 1'b1, 1'b0, 1'b1);
  endfunction

  // ---------------- driving ----------------

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgPwmPeriod:  period_cfg  = data[PeriodW-1:0];
      CfgCommandMax: cmax_cfg    = data[CmdMaxW-1:0];
      CfgMotorCount: count_cfg   = data[CountW-1:0];
      CfgRevMask:    revmask_cfg = data[MaskW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // leaves valid high; the caller either sends again at once or calls wait_idle
  task automatic send_cmd(logic [ReqW-1:0] req, logic [IdxW-1:0] idx,
                          logic signed [SpeedW-1:0] speed, logic coast);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    motor_index   <= idx;
    speed_command <= speed;
    stop_coast    <= coast;
    do @(posedge clk_i); while (!in_ready_o);
    predict_command(req, idx, speed, coast);
    commands_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [SpeedW-1:0] rand_speed();
    int mag;
    case ($urandom_range(0, 7))
      0:       mag = 0;
      1:       mag = 65535;
      2:       mag = int'(cmax_cfg);
      3, 4:    mag = (cmax_cfg == 0) ? 0 : $urandom_range(1, cmax_cfg);
      default: mag = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 1)) mag = -mag;
    return mag[SpeedW-1:0];
  endfunction

  task automatic random_command();
    int unsigned pick;
    logic [ReqW-1:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 60) req = ReqSetSpeed;
    else if (pick < 75) req = ReqStop;
    else if (pick < 81) req = ReqPowerOn;
    else if (pick < 85) req = ReqPowerOff;
    else if (pick < 90) req = ReqStopAll;
    else req = ReqW'($urandom_range(ReqUnusedLo, ReqUnusedHi));
    send_cmd(req, IdxW'($urandom_range(0, NumMotors - 1)), rand_speed(),
             1'($urandom_range(0, 1)));
  endtask

  task automatic random_config();
    int unsigned period;
    int unsigned cmax;
    int unsigned count;
    case ($urandom_range(0, 5))
      0:       period = 1;
      1:       period = 65535;
      2:       period = $urandom_range(1, 255);
      default: period = $urandom_range(1, 65535);
    endcase
    case ($urandom_range(0, 5))
      0:       cmax = 1;
      1:       cmax = 65535;
      2:       cmax = $urandom_range(1, 255);
      default: cmax = $urandom_range(1, 65535);
    endcase
    count = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    write_cfg(CfgPwmPeriod, CfgDataW'(period));
    write_cfg(CfgCommandMax, CfgDataW'(cmax));
    write_cfg(CfgMotorCount, CfgDataW'(count));
    write_cfg(CfgRevMask, CfgDataW'($urandom_range(0, 15)));
  endtask

  // ---------------- tests ----------------

  task automatic test_directed_basic();
    idle_en  = 1'b1;
    stall_en = 1'b1;
    send_cmd(ReqSetSpeed, 2'd0, 17'sd500, 1'b0);
    send_cmd(ReqSetSpeed, 2'd0, 17'sd0, 1'b0);
    send_cmd(ReqStop, 2'd1, 17'sd0, 1'b1);
    send_cmd(ReqPowerOn, 2'd0, 17'sd0, 1'b0);
    send_cmd(ReqSetSpeed, 2'd0, 17'sd65535, 1'b0);
    send_cmd(ReqSetSpeed, 2'd0, -17'sd65535, 1'b0);
    send_cmd(ReqSetSpeed, 2'd0, -17'sd1, 1'b0);
    send_cmd(ReqSetSpeed, 2'd1, 17'sd333, 1'b1);
    send_cmd(ReqSetSpeed, 2'd2, 17'sd100, 1'b0);
    send_cmd(ReqStop, 2'd3, 17'sd0, 1'b0);
    send_cmd(ReqUnusedLo, 2'd0, 17'sd7, 1'b0);
    send_cmd(ReqUnusedHi, 2'd3, -17'sd7, 1'b1);
    send_cmd(ReqStop, 2'd1, 17'sd0, 1'b0);
    send_cmd(ReqStopAll, 2'd0, 17'sd0, 1'b0);
    send_cmd(ReqPowerOff, 2'd0, 17'sd0, 1'b0);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_cfg(CfgRevMask, 16'd15);
    write_cfg(CfgMotorCount, 16'd4);
    write_cfg(CfgPwmPeriod, 16'd65535);
    write_cfg(CfgCommandMax, 16'd1);
    send_cmd(ReqPowerOn, 2'd0, 17'sd0, 1'b0);
    send_cmd(ReqSetSpeed, 2'd3, 17'sd1, 1'b0);
    send_cmd(ReqSetSpeed, 2'd2, -17'sd65535, 1'b0);
    send_cmd(ReqSetSpeed, 2'd1, 17'sd0, 1'b1);
    wait_idle();
    // zero command limit clamps everything to a brake
    write_cfg(CfgCommandMax, 16'd0);
    send_cmd(ReqSetSpeed, 2'd1, 17'sd5, 1'b0);
    wait_idle();
    write_cfg(CfgPwmPeriod, 16'd0);
    write_cfg(CfgCommandMax, 16'd65535);
    send_cmd(ReqSetSpeed, 2'd0, 17'sd32768, 1'b0);
    wait_idle();
    // no motors in use: broadcasts give no result
    write_cfg(CfgMotorCount, 16'd0);
    send_cmd(ReqPowerOn, 2'd0, 17'sd0, 1'b0);
    send_cmd(ReqSetSpeed, 2'd0, 17'sd100, 1'b0);
    send_cmd(ReqStop, 2'd0, 17'sd0, 1'b1);
    wait_idle();
    write_cfg(CfgMotorCount, 16'd7);
    send_cmd(ReqStopAll, 2'd0, 17'sd0, 1'b0);
    send_cmd(ReqPowerOff, 2'd0, 17'sd0, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      idle_en  = ($urandom_range(0, 3) != 0);
      stall_en = ($urandom_range(0, 3) != 0);
      random_config();
      if ($urandom_range(0, 9) != 0) send_cmd(ReqPowerOn, 2'd0, 17'sd0, 1'b0);
      repeat (36) random_command();
      wait_idle();
    end
  endtask

  task automatic test_streaming();
    idle_en  = 1'b0;
    stall_en = 1'b0;
    random_config();
    send_cmd(ReqPowerOn, 2'd0, 17'sd0, 1'b0);
    repeat (30) random_command();
    wait_idle();
  endtask

  // ---------------- result side ----------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!out_ready) begin
      out_ready <= 1'b1;
    end else if (stall_en && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void flag_mismatch(string what, motor_result_t want, motor_result_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%s: exp motor %0d pins %b%b duty %0d st %b pwr %b last %b",
               what, want.motor, want.pin_a, want.pin_b, want.duty, want.status, want.power,
               want.last);
      $display("  got motor %0d pins %b%b duty %0d st %b pwr %b last %b",
               got.motor, got.pin_a, got.pin_b, got.duty, got.status, got.power, got.last);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    motor_result_t got;
    motor_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      got.motor  = motor_out_o;
      got.pin_a  = pin_a_o;
      got.pin_b  = pin_b_o;
      got.duty   = duty_out_o;
      got.status = status_o;
      got.power  = power_on_out_o;
      got.last   = last_result_o;
      results_seen++;
      if (expected_results_q.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_results_q.pop_front();
        if (got.motor !== want.motor || got.pin_a !== want.pin_a || got.pin_b !== want.pin_b ||
            got.duty !== want.duty || got.status !== want.status ||
            got.power !== want.power || got.last !== want.last)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("** h_bridge_motor_command_unit: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CfgPwmPeriod;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    req_type      <= ReqSetSpeed;
    motor_index   <= '0;
    speed_command <= '0;
    stop_coast    <= 1'b0;
    idle_en       = 1'b0;
    stall_en      = 1'b0;
    period_cfg    = PwmPeriodRst;
    cmax_cfg      = CommandMaxRst;
    count_cfg     = MotorCountRst;
    revmask_cfg   = RevMaskRst;
    power_state   = 1'b0;
    for (int i = 0; i < NumMotors; i++) begin
      dir_state[i]    = DirStop;
      bridge_state[i] = PinsCoast;
      duty_state[i]   = PwmPeriodRst;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basic();
    test_config_extremes();
    test_random_traffic();
    test_streaming();
    $display("ran %0d commands and checked %0d results over %0d register writes",
             commands_sent, results_seen, cfg_writes);
    $display("mismatches: %0d, results still owed: %0d", mismatches, expected_results_q.size());
    if (mismatches == 0 && expected_results_q.size() == 0) begin
      $display("** h_bridge_motor_command_unit: PASSED **");
    end else begin
      $display("** h_bridge_motor_command_unit: FAILED **");
    end
    $finish;
  end

endmodule
